// ===== rtl/upc_pkg.sv =====
`timescale 1ns / 1ps

package upc_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Decode phase codes.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  // One item's worth of output: up to three bytes, plus the string end flag.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       last;
  } upc_job_t;

  // Letters and digits pass through the encoder untouched.
  function automatic logic is_plain(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Only meaningful where is_hex holds.
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b <= 8'h46) begin
      v = b - 8'h37;
    end else begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

  // Uppercase hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h37 + {4'h0, nib};
  endfunction

endpackage

// ===== rtl/upc_front.sv =====
`timescale 1ns / 1ps

module upc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              acc,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output upc_pkg::upc_job_t job,
  output logic              job_push
);
  import upc_pkg::*;

  logic       mode_r;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       hexb, pctb;
  logic [7:0] dec_byte;

  assign hexb     = is_hex(in_byte);
  assign pctb     = (in_byte == PCT_CHAR);
  assign dec_byte = {hex_val(held_r), hex_val(in_byte)};

  always_comb begin
    job       = '0;
    job.last  = in_last;
    phase_nxt = phase_r;
    if (!mode_r) begin
      if (is_plain(in_byte)) begin
        job.cnt = 2'd1;
        job.b0  = in_byte;
      end else begin
        job.cnt = 2'd3;
        job.b0  = PCT_CHAR;
        job.b1  = hex_char(in_byte[7:4]);
        job.b2  = hex_char(in_byte[3:0]);
      end
    end else begin
      unique case (phase_r)
        PH_PCT: begin
          if (hexb) begin
            if (in_last) begin
              job.cnt   = 2'd2;
              job.b0    = PCT_CHAR;
              job.b1    = in_byte;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_DIGIT;
            end
          end else if (pctb) begin
            job.b0 = PCT_CHAR;
            job.b1 = PCT_CHAR;
            if (in_last) begin
              job.cnt   = 2'd2;
              phase_nxt = PH_IDLE;
            end else begin
              job.cnt   = 2'd1;
              phase_nxt = PH_PCT;
            end
          end else begin
            job.cnt   = 2'd2;
            job.b0    = PCT_CHAR;
            job.b1    = in_byte;
            phase_nxt = PH_IDLE;
          end
        end
        PH_DIGIT: begin
          if (hexb) begin
            job.cnt   = 2'd1;
            job.b0    = dec_byte;
            phase_nxt = PH_IDLE;
          end else begin
            job.b0 = PCT_CHAR;
            job.b1 = held_r;
            if (pctb) begin
              job.b2 = PCT_CHAR;
              if (in_last) begin
                job.cnt   = 2'd3;
                phase_nxt = PH_IDLE;
              end else begin
                job.cnt   = 2'd2;
                phase_nxt = PH_PCT;
              end
            end else begin
              job.cnt   = 2'd3;
              job.b2    = in_byte;
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
          if (pctb) begin
            if (in_last) begin
              job.cnt   = 2'd1;
              job.b0    = PCT_CHAR;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_PCT;
            end
          end else begin
            job.cnt   = 2'd1;
            job.b0    = in_byte;
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end
    held_nxt = (phase_nxt == PH_DIGIT) ? in_byte : 8'h00;
  end

  assign job_push = acc && (job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (cfg_we) begin
      mode_r  <= cfg_wdata;
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (acc && mode_r) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== rtl/upc_fifo.sv =====
`timescale 1ns / 1ps

module upc_fifo #(
  parameter int QDEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upc_pkg::upc_job_t wr_job,
  output logic              full,
  output logic              not_empty,
  output upc_pkg::upc_job_t rd_job,
  input  logic              pop
);
  import upc_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

  upc_job_t        mem_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign rd_job    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/upc_back.sv =====
`timescale 1ns / 1ps

module upc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  upc_pkg::upc_job_t job,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import upc_pkg::*;

  logic [1:0] idx_r;
  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load, fin;
  logic [7:0] sel_byte;

  assign load = job_valid && (!vld_r || !out_stall);
  assign fin  = (idx_r == job.cnt - 2'd1);
  assign job_pop = load && fin;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = job.b0;
      2'd1:    sel_byte = job.b1;
      default: sel_byte = job.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= fin ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      last_r <= job.last && fin;
    end
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/uri_percent_codec.sv =====
`timescale 1ns / 1ps

// URI percent encoder and decoder for a byte stream. With mode at 0 the block
// encodes: letters and digits pass through, and every other byte leaves as a
// '%' followed by two uppercase hex digits. With mode at 1 it decodes: a '%'
// and two hex digits (either case) become one byte, an incomplete escape is
// passed on raw, and anything still pending when a byte marked last arrives
// is flushed raw, with out_last on the final byte produced for that string.
// Writing mode also discards any pending escape, so it should only be written
// while the block is idle. A front stage takes one input transfer per cycle
// while the queue has room, works out the zero to three bytes it produces
// and places them in a short job queue of QDEPTH entries; a back stage sends
// one byte per cycle through an output register while out_stall is low. A
// plain byte is registered in the queue, then in the output register; an
// escape yields three bytes, and the input stalls only when the queue is full.
module uri_percent_codec #(
  parameter int QDEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import upc_pkg::*;

  upc_job_t wr_job, rd_job;
  logic     acc, push, full, not_empty, pop;

  // An input transfer completes whenever the job queue has room.
  assign in_stall = full;
  assign acc      = in_valid && !full;

  upc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_mode),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .job       (wr_job),
    .job_push  (push)
  );

  // Jobs that produce no bytes (a '%' or a first hex digit held for later) never enter the queue.
  upc_fifo #(
    .QDEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_job    (wr_job),
    .full      (full),
    .not_empty (not_empty),
    .rd_job    (rd_job),
    .pop       (pop)
  );

  upc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (not_empty),
    .job       (rd_job),
    .job_pop   (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
